// ----- sv/modular_exponentiation_assert.svh -----
// Assertion shorthands for the modular exponentiation block.
// Both expect aclk in the scope where they are used; MEXP_ASSERT also expects aresetn.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Check a property while out of reset
`define MEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/mexp_pkg.sv -----
package mexp_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned PROD_W       = 2 * DATA_W;
    localparam int unsigned EXP_W        = 64;
    localparam int unsigned S_TDATA_W    = DATA_W + EXP_W;
    localparam int unsigned EXP_BITS_DEF = 64;
    localparam int unsigned RED_CNT_W    = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t MODULUS_RESET = 32'd1000000007;
    localparam word_t WORD_ONE      = 32'd1;

    // Request to and response from the shared modular multiplier
    typedef struct packed {
        logic  start;
        word_t op_a;
        word_t op_b;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t res;
    } mm_rsp_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_MUL,
        MM_RED
    } mm_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_BASE,
        SEQ_STEP,
        SEQ_MULT,
        SEQ_SQUARE,
        SEQ_DONE
    } seq_state_t;

endpackage

// ----- sv/modular_exponentiation.sv -----
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata: base, exponent
// m_        out  m_tvalid/m_tready   m_tdata: result
// cfg_      in   cfg_valid/cfg_ready cfg_data: modulus
//
// One shared modular multiplier does all work: after its request a product goes
// through capture, load and 32 reduction steps; a zero modulus skips the reduction.
// After the input transaction the base is reduced, then each exponent bit up to the
// highest set one gets a multiply if set and a square; then result and s_tready return.
// s_tready stays low while an item is in progress or its result waits to move.
// Reset is synchronous, active low, and restores the modulus to 1000000007.
module modular_exponentiation #(
    parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0]  s_tdata,   // base [31:0], exponent [95:32]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mexp_pkg::DATA_W-1:0]     m_tdata,   // result [31:0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mexp_pkg::DATA_W-1:0]     cfg_data   // modulus [31:0]
);
    import mexp_pkg::*;

    word_t   modulus_reg, modulus_next;
    logic    m_tvalid_reg, m_tvalid_next;
    word_t   m_tdata_reg, m_tdata_next;
    logic    res_valid;
    logic    res_ready;
    word_t   res_data;
    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    mexp_seq #(
        .EXP_BITS (EXP_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .modulus     (modulus_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_base     (s_tdata[DATA_W-1:0]),
        .in_exponent (s_tdata[S_TDATA_W-1:DATA_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mm_req      (mm_req),
        .mm_rsp      (mm_rsp)
    );

    mexp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // Take the modulus on any configuration transaction
    assign cfg_ready    = 1'b1;
    assign modulus_next = (cfg_valid && cfg_ready) ? cfg_data : modulus_reg;

    // Hold the result until the output transaction completes
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) m_tdata_next = res_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MODULUS_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            modulus_reg  <= modulus_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- sv/mexp_modmul.sv -----
// Shared modular multiplier: one registered 32x32 product, then a
// restoring reduction that shifts in one low product bit per cycle.
// Operands must already be below the modulus, so the high product word
// is a valid starting remainder. A zero modulus means 2^32: the low
// product word is returned without reduction.
module mexp_modmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  mexp_pkg::word_t   modulus,
    input  mexp_pkg::mm_req_t req,
    output mexp_pkg::mm_rsp_t rsp
);
    import mexp_pkg::*;

    mm_state_t             state_reg, state_next;
    logic [PROD_W-1:0]     prod_reg;
    word_t                 rem_reg, rem_next;
    word_t                 low_reg;
    logic [RED_CNT_W-1:0]  cnt_reg;
    logic                  done_reg, done_next;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;
    logic                  last_step;
    logic                  mod_zero;

    // One reduction step: shift in the next bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, low_reg[DATA_W-1]};
        diff      = trial - {1'b0, modulus};
        rem_next  = (trial >= {1'b0, modulus}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        last_step = (cnt_reg == RED_CNT_W'(DATA_W - 1));
        mod_zero  = (modulus == '0);
        done_next = ((state_reg == MM_MUL) && mod_zero) ||
                    ((state_reg == MM_RED) && last_step);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MM_IDLE: begin
                if (req.start) state_next = MM_MUL;
            end
            MM_MUL: begin
                state_next = mod_zero ? MM_IDLE : MM_RED;
            end
            MM_RED: begin
                if (last_step) state_next = MM_IDLE;
            end
            default: state_next = MM_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        rsp.done = done_reg;
        rsp.res  = rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath: multiply, load remainder, then step the reduction
    always_ff @(posedge aclk) begin
        case (state_reg)
            MM_IDLE: begin
                if (req.start) prod_reg <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
            end
            MM_MUL: begin
                rem_reg <= mod_zero ? prod_reg[DATA_W-1:0] : prod_reg[PROD_W-1:DATA_W];
                low_reg <= prod_reg[DATA_W-1:0];
                cnt_reg <= '0;
            end
            MM_RED: begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[DATA_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + RED_CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/mexp_seq.sv -----
// Square-and-multiply sequencer: reduces the base, then walks the
// exponent from its lowest bit, issuing one product at a time to the
// shared multiplier. Stops as soon as no set exponent bit remains.
module mexp_seq #(
    parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mexp_pkg::word_t             modulus,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mexp_pkg::word_t             in_base,
    input  logic [mexp_pkg::EXP_W-1:0]  in_exponent,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mexp_pkg::word_t             res_data,
    output mexp_pkg::mm_req_t           mm_req,
    input  mexp_pkg::mm_rsp_t           mm_rsp
);
    import mexp_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [EXP_BITS-1:0] exp_reg;
    word_t               acc_reg;
    word_t               run_reg;
    logic                exp_zero;

    assign exp_zero = (exp_reg == '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (in_valid) state_next = SEQ_LOAD;
            end
            SEQ_LOAD: begin
                state_next = SEQ_BASE;
            end
            SEQ_BASE: begin
                if (mm_rsp.done) state_next = SEQ_STEP;
            end
            SEQ_STEP: begin
                if (exp_zero)        state_next = SEQ_DONE;
                else if (exp_reg[0]) state_next = SEQ_MULT;
                else                 state_next = SEQ_SQUARE;
            end
            SEQ_MULT: begin
                if (mm_rsp.done) state_next = SEQ_SQUARE;
            end
            SEQ_SQUARE: begin
                if (mm_rsp.done) state_next = SEQ_STEP;
            end
            SEQ_DONE: begin
                if (res_ready) state_next = SEQ_IDLE;
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Outputs and multiplier requests
    always_comb begin
        in_ready     = (state_reg == SEQ_IDLE);
        res_valid    = (state_reg == SEQ_DONE);
        res_data     = acc_reg;
        mm_req.start = 1'b0;
        mm_req.op_a  = run_reg;
        mm_req.op_b  = run_reg;
        case (state_reg)
            SEQ_LOAD: begin
                // base times one reduces the base
                mm_req.start = 1'b1;
                mm_req.op_b  = WORD_ONE;
            end
            SEQ_STEP: begin
                mm_req.start = !exp_zero;
                if (exp_reg[0]) mm_req.op_a = acc_reg;
            end
            SEQ_MULT: begin
                // square straight after the multiply completes
                mm_req.start = mm_rsp.done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            SEQ_IDLE: begin
                if (in_valid) begin
                    run_reg <= in_base;
                    exp_reg <= in_exponent[EXP_BITS-1:0];
                    acc_reg <= (modulus == WORD_ONE) ? '0 : WORD_ONE;
                end
            end
            SEQ_BASE: begin
                if (mm_rsp.done) run_reg <= mm_rsp.res;
            end
            SEQ_MULT: begin
                if (mm_rsp.done) acc_reg <= mm_rsp.res;
            end
            SEQ_SQUARE: begin
                if (mm_rsp.done) begin
                    run_reg <= mm_rsp.res;
                    exp_reg <= exp_reg >> 1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/mexp_checker.sv -----
`include "modular_exponentiation_assert.svh"

module mexp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mexp_pkg::DATA_W-1:0]  m_tdata
);

    // A stalled result holds its value
    `MEXP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // After accepting an item the block stays busy while it loads and starts the base reduction
    `MEXP_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready ##1 !s_tready, "input taken while an item is in progress")

    // Reset leaves no result pending and the input side open
    `MEXP_ASSERT_ALWAYS(a_reset_state, !aresetn |=> !m_tvalid && s_tready, "wrong state after reset")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
